/* rtl/twra_pkg.sv */
package twra_pkg;

   localparam int MAX_PARTICLES = 256;
   localparam int QUANTITIES    = 8;
   localparam int ENTRIES       = MAX_PARTICLES * QUANTITIES;
   localparam int ADDR_W        = $clog2(ENTRIES);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam int ELAPSED_W = 48;
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

   // action codes as they arrive on the request port
   localparam logic [2:0] ACT_STORE   = 3'd0;
   localparam logic [2:0] ACT_FOLD    = 3'd1;
   localparam logic [2:0] ACT_ADVANCE = 3'd2;
   localparam logic [2:0] ACT_CLEAR   = 3'd3;
   localparam logic [2:0] ACT_READ    = 3'd4;

   typedef enum logic [2:0] {
      OP_STORE,
      OP_FOLD,
      OP_ADVANCE,
      OP_CLEAR,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type             op;
      logic               addr_ok;
      logic [ADDR_W-1:0]  addr;
      logic signed [31:0] sample_x;
      logic signed [31:0] sample_y;
      logic signed [31:0] sample_z;
      logic [31:0]        time_step;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

endpackage

/* rtl/time_weighted_running_average.sv */
// time-weighted running mean table, Q16.16
// request channel: an item transfers at a rising edge with start high and busy low.
//   req_action selects store, fold, advance time, clear time or read (codes above
//   read act as read) on the entry addressed by req_particle_id and req_quantity.
// response channel: one result per item, on the rsp_ ports for exactly one cycle
//   while rsp_valid is high; the receiver cannot hold it off.
// a two-entry queue sits between the request side and the execution unit, so
// requests keep transferring while an earlier item is still being worked on;
// busy rises only when the queue is full.
// store, time and read items pass from the queue into the item register and give
// their result through the response register, with the table read in the load state.
// a fold runs 9 partial products through one shared 33x33 multiplier, each in a
// multiply and an accumulate state, then a bit-per-cycle divider that runs all three
// components side by side, plus load, sign and write-back.
// the execution unit takes one item at a time, the next only once it is back in idle.
// reset clears the elapsed-time accumulator and the queue; mean table entries
// hold nothing valid until stored.
module time_weighted_running_average import twra_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_action,
   input  logic [7:0]         req_particle_id,
   input  logic [2:0]         req_quantity,
   input  logic signed [31:0] req_sample_x,
   input  logic signed [31:0] req_sample_y,
   input  logic signed [31:0] req_sample_z,
   input  logic [31:0]        req_time_step,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_mean_x,
   output logic signed [31:0] rsp_mean_y,
   output logic signed [31:0] rsp_mean_z,
   output logic               rsp_elapsed_saturated
);

   queue_head_type head;
   logic           pop;

   twra_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_particle_id (req_particle_id),
      .req_quantity    (req_quantity),
      .req_sample_x    (req_sample_x),
      .req_sample_y    (req_sample_y),
      .req_sample_z    (req_sample_z),
      .req_time_step   (req_time_step),
      .head            (head),
      .pop             (pop)
   );

   twra_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .head                  (head),
      .pop                   (pop),
      .rsp_valid             (rsp_valid),
      .rsp_mean_x            (rsp_mean_x),
      .rsp_mean_y            (rsp_mean_y),
      .rsp_mean_z            (rsp_mean_z),
      .rsp_elapsed_saturated (rsp_elapsed_saturated)
   );

endmodule

/* rtl/twra_ram.sv */
module twra_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/twra_front.sv */
module twra_front import twra_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_action,
   input  logic [7:0]         req_particle_id,
   input  logic [2:0]         req_quantity,
   input  logic signed [31:0] req_sample_x,
   input  logic signed [31:0] req_sample_y,
   input  logic signed [31:0] req_sample_z,
   input  logic [31:0]        req_time_step,
   output queue_head_type     head,
   input  logic               pop
);

   item_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              push;
   item_type          item_in;
   logic [31:0]       addr_full;

   always_comb begin
      unique case (req_action)
         ACT_STORE:   item_in.op = OP_STORE;
         ACT_FOLD:    item_in.op = OP_FOLD;
         ACT_ADVANCE: item_in.op = OP_ADVANCE;
         ACT_CLEAR:   item_in.op = OP_CLEAR;
         default:     item_in.op = OP_READ;
      endcase
      addr_full = 32'(req_particle_id) * 32'(QUANTITIES) + 32'(req_quantity);
      item_in.addr_ok   = (32'(req_particle_id) < 32'(MAX_PARTICLES)) &&
                          (32'(req_quantity) < 32'(QUANTITIES));
      item_in.addr      = addr_full[ADDR_W-1:0];
      item_in.sample_x  = req_sample_x;
      item_in.sample_y  = req_sample_y;
      item_in.sample_z  = req_sample_z;
      item_in.time_step = req_time_step;
   end

   assign busy = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push = start && !busy;

   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            slot_ff[wr_ptr_ff] <= item_in;
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + QCNT_W'(push) - QCNT_W'(pop);
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty queue");
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push lost");

endmodule

/* rtl/twra_back.sv */
module twra_back import twra_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  queue_head_type     head,
   output logic               pop,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_mean_x,
   output logic signed [31:0] rsp_mean_y,
   output logic signed [31:0] rsp_mean_z,
   output logic               rsp_elapsed_saturated
);

   localparam int NUM_W  = 82;
   localparam int MAG_W  = 81;
   localparam int DIV_W  = ELAPSED_W + 1;
   localparam int PROD_W = 66;
   localparam logic [1:0] TERM_LO = 2'd0;
   localparam logic [1:0] TERM_HI = 2'd1;
   localparam logic [1:0] TERM_DT = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_MUL,
      S_ACC,
      S_SIGN,
      S_DIV,
      S_WB
   } state_type;

   state_type                 state_ff;
   item_type                  item_ff;
   logic [ELAPSED_W-1:0]      elapsed_ff;
   logic [ELAPSED_W-1:0]      elapsed_in;
   logic [DIV_W-1:0]          adv_sum;
   logic [DIV_W-1:0]          div_ff;
   logic [DIV_W-1:0]          divisor_in;
   logic signed [31:0]        mean_ff [3];
   logic signed [NUM_W-1:0]   num_ff [3];
   logic                      neg_ff [3];
   logic [DIV_W-1:0]          rem_ff [3];
   logic [31:0]               quo_ff [3];
   logic [DIV_W:0]            rem_shift [3];
   logic [DIV_W:0]            rem_diff [3];
   logic [31:0]               result [3];
   logic [NUM_W-1:0]          num_abs [3];
   logic [1:0]                comp_ff;
   logic [1:0]                term_ff;
   logic [4:0]                step_ff;
   logic signed [32:0]        mul_a;
   logic signed [32:0]        mul_b;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [NUM_W-1:0]   prod_ext;
   logic signed [31:0]        sample [3];
   logic [95:0]               rd_data;
   logic signed [31:0]        rd_mean [3];
   logic                      wr_en;
   logic [95:0]               wr_data;
   logic                      rsp_valid_ff;
   logic signed [31:0]        rsp_mean_ff [3];
   logic                      rsp_sat_ff;

   twra_ram #(.WIDTH(96), .DEPTH(ENTRIES)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (item_ff.addr),
      .wr_data (wr_data),
      .rd_addr (head.item.addr),
      .rd_data (rd_data)
   );

   assign pop = (state_ff == S_IDLE) && head.valid;

   assign sample[0] = item_ff.sample_x;
   assign sample[1] = item_ff.sample_y;
   assign sample[2] = item_ff.sample_z;
   assign rd_mean[0] = rd_data[31:0];
   assign rd_mean[1] = rd_data[63:32];
   assign rd_mean[2] = rd_data[95:64];

   assign adv_sum    = {1'b0, elapsed_ff} + DIV_W'(item_ff.time_step);
   assign divisor_in = adv_sum;

   always_comb begin
      case (item_ff.op)
         OP_ADVANCE: elapsed_in = adv_sum[DIV_W-1] ? ELAPSED_MAX : adv_sum[ELAPSED_W-1:0];
         OP_CLEAR:   elapsed_in = '0;
         default:    elapsed_in = elapsed_ff;
      endcase
   end

   // one shared signed multiplier; elapsed time is taken in a low and a high part
   always_comb begin
      case (term_ff)
         TERM_LO: begin
            mul_a = {1'b0, elapsed_ff[31:0]};
            mul_b = 33'(mean_ff[comp_ff]);
         end
         TERM_HI: begin
            mul_a = {17'b0, elapsed_ff[ELAPSED_W-1:32]};
            mul_b = 33'(mean_ff[comp_ff]);
         end
         default: begin
            mul_a = {1'b0, item_ff.time_step};
            mul_b = 33'(sample[comp_ff]);
         end
      endcase
   end

   assign prod_ext = NUM_W'(prod_ff);

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         num_abs[c]   = num_ff[c][NUM_W-1] ? NUM_W'(-num_ff[c]) : NUM_W'(num_ff[c]);
         rem_shift[c] = {rem_ff[c], quo_ff[c][31]};
         rem_diff[c]  = rem_shift[c] - {1'b0, div_ff};
         result[c]    = neg_ff[c] ? 32'(-quo_ff[c]) : quo_ff[c];
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_data = {item_ff.sample_z, item_ff.sample_y, item_ff.sample_x};
      if (state_ff == S_LOAD && item_ff.op == OP_STORE && item_ff.addr_ok) begin
         wr_en = 1'b1;
      end else if (state_ff == S_WB) begin
         wr_en   = 1'b1;
         wr_data = {result[2], result[1], result[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_sat_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (head.valid) begin
                  item_ff  <= head.item;
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               elapsed_ff <= elapsed_in;
               for (int c = 0; c < 3; c++) begin
                  mean_ff[c] <= rd_mean[c];
                  num_ff[c]  <= '0;
               end
               comp_ff <= '0;
               term_ff <= TERM_LO;
               div_ff  <= divisor_in;
               if (item_ff.op == OP_FOLD && item_ff.addr_ok && divisor_in != '0) begin
                  state_ff <= S_MUL;
               end else begin
                  for (int c = 0; c < 3; c++) begin
                     if (!item_ff.addr_ok) begin
                        rsp_mean_ff[c] <= '0;
                     end else if (item_ff.op == OP_STORE) begin
                        rsp_mean_ff[c] <= sample[c];
                     end else begin
                        rsp_mean_ff[c] <= rd_mean[c];
                     end
                  end
                  rsp_sat_ff   <= (elapsed_in == ELAPSED_MAX);
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            S_MUL: begin
               prod_ff  <= mul_a * mul_b;
               state_ff <= S_ACC;
            end
            S_ACC: begin
               num_ff[comp_ff] <= num_ff[comp_ff] +
                                  ((term_ff == TERM_HI) ? (prod_ext <<< 32) : prod_ext);
               if (term_ff == TERM_DT) begin
                  term_ff <= TERM_LO;
                  comp_ff <= comp_ff + 1'b1;
                  state_ff <= (comp_ff == 2'd2) ? S_SIGN : S_MUL;
               end else begin
                  term_ff  <= term_ff + 1'b1;
                  state_ff <= S_MUL;
               end
            end
            S_SIGN: begin
               // quotient fits 32 bits, so the upper numerator bits start as remainder
               for (int c = 0; c < 3; c++) begin
                  neg_ff[c] <= num_ff[c][NUM_W-1];
                  rem_ff[c] <= num_abs[c][MAG_W-1:32];
                  quo_ff[c] <= num_abs[c][31:0];
               end
               step_ff  <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               for (int c = 0; c < 3; c++) begin
                  if (!rem_diff[c][DIV_W]) begin
                     rem_ff[c] <= rem_diff[c][DIV_W-1:0];
                     quo_ff[c] <= {quo_ff[c][30:0], 1'b1};
                  end else begin
                     rem_ff[c] <= rem_shift[c][DIV_W-1:0];
                     quo_ff[c] <= {quo_ff[c][30:0], 1'b0};
                  end
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == 5'd31) begin
                  state_ff <= S_WB;
               end
            end
            S_WB: begin
               for (int c = 0; c < 3; c++) begin
                  rsp_mean_ff[c] <= result[c];
               end
               rsp_sat_ff   <= (elapsed_ff == ELAPSED_MAX);
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_mean_x            = rsp_mean_ff[0];
   assign rsp_mean_y            = rsp_mean_ff[1];
   assign rsp_mean_z            = rsp_mean_ff[2];
   assign rsp_elapsed_saturated = rsp_sat_ff;

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("back-to-back response strobes");
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> div_ff != '0)
      else $error("division by zero");
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_LOAD || state_ff == S_WB))
      else $error("table write outside load or write-back");
   a_wb_strobe: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WB |=> rsp_valid_ff)
      else $error("fold finished without response");

endmodule

/* tb/time_weighted_running_average_tb.sv */
`timescale 1ns / 1ps

module time_weighted_running_average_tb;
   import twra_pkg::*;

   localparam logic [2:0] ACT_ALIAS_LAST = 3'd7;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct {
      logic signed [31:0] mx;
      logic signed [31:0] my;
      logic signed [31:0] mz;
      logic               sat;
   } mean_result_type;

   class mean_scoreboard;
      logic [31:0]          mean_tab [ENTRIES][3];
      bit                   stored [ENTRIES];
      int                   stored_idx [$];
      logic [ELAPSED_W-1:0] elapsed;
      mean_result_type      pending_means [$];
      int                   errors;

      function void clear_state();
         foreach (stored[i]) stored[i] = 0;
         stored_idx.delete();
         elapsed = '0;
         errors = 0;
      endfunction

      // exact weighted mean, quotient truncated toward zero
      function logic [31:0] fold_mean(logic [31:0] m, logic [31:0] s, logic [31:0] dt);
         logic signed [127:0] num;
         logic signed [127:0] den;
         logic signed [127:0] q;
         logic [48:0]         total;
         total = {1'b0, elapsed} + {17'd0, dt};
         num = $signed({80'd0, elapsed}) * $signed({{96{m[31]}}, m})
             + $signed({96'd0, dt}) * $signed({{96{s[31]}}, s});
         den = $signed({79'd0, total});
         q = num / den;
         return q[31:0];
      endfunction

      function void note_transfer(logic [2:0] act, logic [7:0] pid, logic [2:0] qty,
                                  logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                                  logic [31:0] dt);
         int              idx;
         logic [48:0]     total;
         mean_result_type r;
         idx = pid * QUANTITIES + qty;
         total = {1'b0, elapsed} + {17'd0, dt};
         case (act)
            ACT_STORE: begin
               mean_tab[idx][0] = sx;
               mean_tab[idx][1] = sy;
               mean_tab[idx][2] = sz;
               if (!stored[idx]) stored_idx.push_back(idx);
               stored[idx] = 1;
            end
            ACT_FOLD: begin
               if (total != 0) begin
                  mean_tab[idx][0] = fold_mean(mean_tab[idx][0], sx, dt);
                  mean_tab[idx][1] = fold_mean(mean_tab[idx][1], sy, dt);
                  mean_tab[idx][2] = fold_mean(mean_tab[idx][2], sz, dt);
               end
            end
            ACT_ADVANCE: elapsed = total[48] ? ELAPSED_MAX : total[ELAPSED_W-1:0];
            ACT_CLEAR: elapsed = '0;
            default: ;
         endcase
         r.mx = mean_tab[idx][0];
         r.my = mean_tab[idx][1];
         r.mz = mean_tab[idx][2];
         r.sat = (elapsed == ELAPSED_MAX);
         pending_means.push_back(r);
      endfunction

      function void check_result(logic [31:0] mx, logic [31:0] my, logic [31:0] mz,
                                 logic sat);
         mean_result_type e;
         if (pending_means.size() == 0) begin
            $error("unexpected result mean=%h %h %h", mx, my, mz);
            errors++;
            return;
         end
         e = pending_means.pop_front();
         if (mx !== e.mx) begin
            $error("mean_x expected %h actual %h", e.mx, mx);
            errors++;
         end
         if (my !== e.my) begin
            $error("mean_y expected %h actual %h", e.my, my);
            errors++;
         end
         if (mz !== e.mz) begin
            $error("mean_z expected %h actual %h", e.mz, mz);
            errors++;
         end
         if (sat !== e.sat) begin
            $error("elapsed_saturated expected %b actual %b", e.sat, sat);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_action;
   logic [7:0]         req_particle_id;
   logic [2:0]         req_quantity;
   logic signed [31:0] req_sample_x;
   logic signed [31:0] req_sample_y;
   logic signed [31:0] req_sample_z;
   logic [31:0]        req_time_step;
   logic               rsp_valid;
   logic signed [31:0] rsp_mean_x;
   logic signed [31:0] rsp_mean_y;
   logic signed [31:0] rsp_mean_z;
   logic               rsp_elapsed_saturated;

   mean_scoreboard sb;
   int             idle_pct;
   int             quiet_cycles;

   time_weighted_running_average dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_particle_id(req_particle_id),
      .req_quantity(req_quantity),
      .req_sample_x(req_sample_x),
      .req_sample_y(req_sample_y),
      .req_sample_z(req_sample_z),
      .req_time_step(req_time_step),
      .rsp_valid(rsp_valid),
      .rsp_mean_x(rsp_mean_x),
      .rsp_mean_y(rsp_mean_y),
      .rsp_mean_z(rsp_mean_z),
      .rsp_elapsed_saturated(rsp_elapsed_saturated)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result(rsp_mean_x, rsp_mean_y, rsp_mean_z, rsp_elapsed_saturated);
   end

   // counts cycles without any transfer on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("time_weighted_running_average verification failed");
            $finish;
         end
      end
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_item(logic [2:0] act, logic [7:0] pid, logic [2:0] qty,
                            logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                            logic [31:0] dt);
      while ($urandom_range(99) < idle_pct) begin
         start = 0;
         @(negedge clock);
      end
      start = 1;
      req_action = act;
      req_particle_id = pid;
      req_quantity = qty;
      req_sample_x = sx;
      req_sample_y = sy;
      req_sample_z = sz;
      req_time_step = dt;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      sb.note_transfer(act, pid, qty, sx, sy, sz, dt);
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_sample();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(3) == 0 ? 32'h0 : 32'hffff_ffff;
         3: return $urandom_range(32'h0003_0000) - 32'h0001_8000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_step();
      case ($urandom_range(9))
         0: return 32'h0;
         1: return 32'hffff_ffff;
         2, 3: return $urandom;
         default: return $urandom_range(32'h0004_0000);
      endcase
   endfunction

   task automatic send_to_entry(logic [2:0] act, int idx, logic [31:0] dt);
      send_item(act, 8'(idx / QUANTITIES), 3'(idx % QUANTITIES),
                pick_sample(), pick_sample(), pick_sample(), dt);
   endtask

   task automatic send_random();
      int          sel;
      int          idx;
      logic [2:0]  act;
      sel = $urandom_range(99);
      if (sel < 20 || sb.stored_idx.size() == 0) act = ACT_STORE;
      else if (sel < 55) act = ACT_FOLD;
      else if (sel < 68) act = ACT_ADVANCE;
      else if (sel < 72) act = ACT_CLEAR;
      else if (sel < 88) act = ACT_READ;
      else act = 3'($urandom_range(ACT_READ + 1, ACT_ALIAS_LAST));
      if (act == ACT_STORE) begin
         // mostly reuse a small set of entries so folds stack up on them
         if ($urandom_range(1) == 0) idx = $urandom_range(15) * QUANTITIES + $urandom_range(7);
         else idx = $urandom_range(ENTRIES - 1);
      end else begin
         idx = sb.stored_idx[$urandom_range(sb.stored_idx.size() - 1)];
      end
      send_to_entry(act, idx, pick_step());
   endtask

   task automatic drain();
      while (sb.pending_means.size() != 0) @(negedge clock);
   endtask

   initial begin
      sb = new();
      sb.clear_state();
      idle_pct = 0;
      reset = 1;
      start = 0;
      req_action = ACT_STORE;
      req_particle_id = '0;
      req_quantity = '0;
      req_sample_x = '0;
      req_sample_y = '0;
      req_sample_z = '0;
      req_time_step = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed corners
      send_item(ACT_STORE, 8'd0, 3'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0);
      send_item(ACT_STORE, 8'd255, 3'd7, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
                32'hffff_ffff);
      send_item(ACT_READ, 8'd0, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0);
      // zero total time leaves the mean alone
      send_item(ACT_FOLD, 8'd0, 3'd0, 32'h1234_5678, 32'h0, 32'h0, 32'h0);
      send_item(ACT_FOLD, 8'd255, 3'd7, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                32'hffff_ffff);
      send_item(ACT_ADVANCE, 8'd0, 3'd0, 32'h0, 32'h0, 32'h0, 32'hffff_ffff);
      send_item(ACT_FOLD, 8'd0, 3'd0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                32'hffff_ffff);
      send_item(ACT_FOLD, 8'd255, 3'd7, 32'h0001_0000, 32'hffff_0000, 32'h0, 32'h0);
      send_item(ACT_ADVANCE, 8'd255, 3'd7, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
      send_item(ACT_FOLD, 8'd0, 3'd0, 32'hffff_ffff, 32'h1, 32'h7fff_ffff, 32'h1);
      send_item(3'd5, 8'd0, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0);
      send_item(3'd6, 8'd255, 3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                32'hffff_ffff);
      send_item(ACT_ALIAS_LAST, 8'd0, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0);
      send_item(ACT_CLEAR, 8'd255, 3'd7, 32'h0, 32'h0, 32'h0, 32'h0);
      send_item(ACT_FOLD, 8'd255, 3'd7, 32'h5555_5555, 32'haaaa_aaaa, 32'h1, 32'h0);
      send_item(ACT_FOLD, 8'd0, 3'd0, 32'haaaa_aaaa, 32'h5555_5555, 32'h0, 32'hffff_ffff);
      send_item(ACT_STORE, 8'haa, 3'd5, 32'h5555_5555, 32'haaaa_aaaa, 32'h1, 32'h0);
      send_item(ACT_STORE, 8'h55, 3'd2, 32'haaaa_aaaa, 32'h5555_5555, 32'hffff_fffe,
                32'h0);

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = phase == 0 ? 33 : (phase == 1 ? 73 : 0);
         for (int n = 0; n < 640; n++) send_random();
      end

      send_item(ACT_FOLD, 8'd255, 3'd7, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'hffff_ffff);
      send_item(ACT_CLEAR, 8'd0, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0);
      start = 0;

      drain();
      repeat (100) @(negedge clock);
      if (sb.errors == 0 && sb.pending_means.size() == 0) begin
         $display("time_weighted_running_average verification clean");
      end else begin
         $display("time_weighted_running_average verification failed");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/twra_pkg.sv
rtl/twra_ram.sv
rtl/twra_front.sv
rtl/twra_back.sv
rtl/time_weighted_running_average.sv
tb/time_weighted_running_average_tb.sv
